/* design/dhbe_pkg.sv */
// shared types, constants and character tables for the digest text encoder
`default_nettype none

package dhbe_pkg;

    localparam int MAX_DIGEST_BYTES = 64;
    localparam int Q_DEPTH          = 2;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CFG_TEXT_MODE     = 2'd0;
    localparam logic [1:0] CFG_DEST_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_DIGEST_LENGTH = 2'd2;

    localparam logic MODE_HEX = 1'b0;
    localparam logic MODE_B64 = 1'b1;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] TERM_CHAR = 8'h00;
    localparam logic [7:0] B64_HI6   = 8'hFC;
    localparam logic [7:0] B64_LO6   = 8'h3F;

    typedef struct packed {
        logic       text_mode;
        logic [7:0] dest_capacity;
        logic [6:0] digest_length;
    } t_cfg;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      nchar;
        logic            fin;
        logic            fin_valid;
        logic            fin_status;
        logic [7:0]      fin_len;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'h0, nib};
        return (nib < 4'd10) ? 8'h30 + v : 8'h57 + v;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            c = 8'h41 + v;
        end else if (idx < 6'd52) begin
            c = 8'h47 + v;
        end else if (idx < 6'd62) begin
            c = v - 8'd4;
        end else if (idx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/dhbe_front.sv */
// front end: accepts digest bytes, tracks message state, builds result commands
`default_nettype none

module dhbe_front import dhbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_accept,
    input  wire logic [7:0] i_byte,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [15:0] r_held,  n_held;
    logic [1:0]  r_fill,  n_fill;
    logic [6:0]  r_seen,  n_seen;
    logic [7:0]  r_cw,    n_cw;

    logic [6:0] eff;
    logic [7:0] seen1;
    logic       last;
    logic       fits;
    logic [7:0] cw_hex;
    logic [8:0] cw_hex1;
    logic [2:0] fill;
    logic       grp_full;
    logic       emit;
    logic [7:0] t0, t1, t2;
    logic [1:0] cnt;
    logic [5:0] i0, i1, i2, i3;
    logic [7:0] avail;
    logic [2:0] ng;
    logic [2:0] nb;
    logic [7:0] cw_b64;
    t_cmd       cmd;

    always_comb begin
        if (i_cfg.digest_length == 7'd0) begin
            eff = 7'd1;
        end else if (i_cfg.digest_length > 7'(MAX_DIGEST_BYTES)) begin
            eff = 7'(MAX_DIGEST_BYTES);
        end else begin
            eff = i_cfg.digest_length;
        end
        seen1 = {1'b0, r_seen} + 8'd1;
        last  = seen1 >= {1'b0, eff};

        // hex path
        fits    = {eff, 1'b0} <= i_cfg.dest_capacity;
        cw_hex  = fits ? r_cw + 8'd2 : r_cw;
        cw_hex1 = {1'b0, cw_hex} + 9'd1;

        // base64 path
        fill     = {1'b0, r_fill} + 3'd1;
        grp_full = fill >= 3'd3;
        emit     = grp_full || last;
        if (grp_full) begin
            t0 = r_held[15:8]; t1 = r_held[7:0]; t2 = i_byte; cnt = 2'd3;
        end else if (fill == 3'd1) begin
            t0 = i_byte; t1 = 8'h00; t2 = 8'h00; cnt = 2'd1;
        end else begin
            t0 = r_held[7:0]; t1 = i_byte; t2 = 8'h00; cnt = 2'd2;
        end
        i0 = 6'((t0 & B64_HI6) >> 2);
        i1 = {t0[1:0], t1[7:4]};
        i2 = {t1[3:0], t2[7:6]};
        i3 = 6'(t2 & B64_LO6);
        avail  = (i_cfg.dest_capacity > r_cw) ? i_cfg.dest_capacity - r_cw : 8'd0;
        ng     = emit ? 3'd4 : 3'd0;
        nb     = (avail < {5'd0, ng}) ? avail[2:0] : ng;
        cw_b64 = r_cw + {5'd0, nb};

        cmd = '0;
        cmd.fin = last;
        n_held = r_held;
        n_fill = r_fill;
        n_seen = last ? 7'd0 : seen1[6:0];
        unique case (i_cfg.text_mode)
            MODE_HEX: begin
                cmd.chars[0] = hex_char(i_byte[7:4]);
                cmd.chars[1] = hex_char(i_byte[3:0]);
                cmd.nchar    = fits ? 3'd2 : 3'd0;
                n_cw         = cw_hex;
                if (!fits) begin
                    cmd.fin_status = 1'b1;
                end else if ({1'b0, i_cfg.dest_capacity} > cw_hex1) begin
                    cmd.fin_valid = 1'b1;
                    cmd.fin_len   = cw_hex1[7:0];
                end else begin
                    cmd.fin_len   = cw_hex;
                end
            end
            MODE_B64: begin
                cmd.chars[0] = b64_char(i0);
                cmd.chars[1] = b64_char(i1);
                cmd.chars[2] = (cnt >= 2'd2) ? b64_char(i2) : PAD_CHAR;
                cmd.chars[3] = (cnt == 2'd3) ? b64_char(i3) : PAD_CHAR;
                cmd.nchar    = nb;
                n_cw         = cw_b64;
                n_held       = {r_held[7:0], i_byte};
                n_fill       = grp_full ? 2'd0 : fill[1:0];
                if (cw_b64 < i_cfg.dest_capacity) begin
                    cmd.fin_valid = 1'b1;
                    cmd.fin_len   = cw_b64 + 8'd1;
                end else begin
                    cmd.fin_status = 1'b1;
                end
            end
            default: begin
                n_cw = r_cw;
            end
        endcase
        if (last) begin
            n_held = '0;
            n_fill = '0;
            n_cw   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fill <= '0;
            r_seen <= '0;
            r_cw   <= '0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_fill <= n_fill;
            r_seen <= n_seen;
            r_cw   <= n_cw;
        end
    end

    assign o_push = i_accept && (cmd.nchar != 3'd0 || cmd.fin);
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

/* design/dhbe_queue.sv */
// short command queue between front and back end
`default_nettype none

module dhbe_queue import dhbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_head
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    assign o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

endmodule

`default_nettype wire

/* design/dhbe_back.sv */
// back end: walks each command into result items behind an output register
`default_nettype none

module dhbe_back import dhbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    input  wire logic i_ready,
    output logic      o_valid,
    output logic [7:0] o_char,
    output logic      o_char_valid,
    output logic      o_done,
    output logic      o_status,
    output logic [7:0] o_len
);

    logic [2:0] r_idx, n_idx;
    logic       r_ovalid;
    logic [7:0] r_char, n_char;
    logic       r_cv,   n_cv;
    logic       r_done, n_done;
    logic       r_st,   n_st;
    logic [7:0] r_len,  n_len;
    logic       load;
    logic [2:0] total;

    always_comb begin
        load  = i_valid && (!r_ovalid || i_ready);
        total = i_cmd.nchar + {2'b00, i_cmd.fin};
        if (r_idx < i_cmd.nchar) begin
            n_char = i_cmd.chars[r_idx[1:0]];
            n_cv   = 1'b1;
            n_done = 1'b0;
            n_st   = 1'b0;
            n_len  = 8'd0;
        end else begin
            n_char = TERM_CHAR;
            n_cv   = i_cmd.fin_valid;
            n_done = 1'b1;
            n_st   = i_cmd.fin_status;
            n_len  = i_cmd.fin_len;
        end
        o_pop = load && (r_idx == total - 3'd1);
        n_idx = o_pop ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= n_idx;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_cv   <= n_cv;
            r_done <= n_done;
            r_st   <= n_st;
            r_len  <= n_len;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_char       = r_char;
    assign o_char_valid = r_cv;
    assign o_done       = r_done;
    assign o_status     = r_st;
    assign o_len        = r_len;

endmodule

`default_nettype wire

/* design/digest_hex_base64_encoder_top.sv */
// top level of the digest hex / base64 text encoder
//
//  channel   direction  payload
//  s_axis    in         tdata[7:0] digest_byte
//  m_axis    out        tdata char_code, status, final_length; tuser char_valid; tlast done
//  cfg       in         index 0 text mode, 1 dest_capacity, 2 digest_length
//
//  a byte is taken every cycle while the two-entry command queue has room
//  the back end sends one item a cycle while the receiver is ready; a byte gives up to two hex
//  chars, three bytes up to four base64 chars, plus a final item per message; the single output port sets the rate
//  reset clears message state and restores the register defaults
//  either side may stall without losing items; the queue absorbs the difference
`default_nettype none

module digest_hex_base64_encoder_top import dhbe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] digest_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] char_code, [8] status, [16:9] final_length
    output logic             m_axis_tuser,   // [0] char_valid
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    t_cfg       r_cfg;
    logic       accept;
    logic       push;
    t_cmd       cmd;
    logic       q_full;
    logic       q_valid;
    t_cmd       q_head;
    logic       pop;
    logic [7:0] char_code;
    logic       status;
    logic [7:0] final_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_mode     <= MODE_HEX;
            r_cfg.dest_capacity <= 8'd0;
            r_cfg.digest_length <= 7'd32;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXT_MODE:     r_cfg.text_mode     <= i_cfg_data[0];
                CFG_DEST_CAPACITY: r_cfg.dest_capacity <= i_cfg_data;
                CFG_DIGEST_LENGTH: r_cfg.digest_length <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    dhbe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    dhbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    dhbe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cmd        (q_head),
        .o_pop        (pop),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_char       (char_code),
        .o_char_valid (m_axis_tuser),
        .o_done       (m_axis_tlast),
        .o_status     (status),
        .o_len        (final_length)
    );

    assign m_axis_tdata = {7'd0, final_length, status, char_code};

endmodule

`default_nettype wire

/* design/dhbe_checker.sv */
// port-level checks for the digest text encoder, bound to the top level
`default_nettype none

module dhbe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'h00)
        else $error("final item carries a non-zero character");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && m_axis_tdata[16:8] == 9'd0)
        else $error("character item with status or length set");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[8]
        |-> !m_axis_tuser && m_axis_tdata[16:9] == 8'd0)
        else $error("failed message reports a terminator or length");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind digest_hex_base64_encoder_top dhbe_checker u_dhbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* dv/tb_digest_hex_base64_encoder_top.sv */
// self-checking testbench for the digest hex / base64 text encoder, with its own predictor
`default_nettype none

module tb_digest_hex_base64_encoder_top;
    import dhbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_BYTES  = 140;
    localparam int MAX_PRINTED   = 200;

    localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";
    localparam logic [8*64-1:0] B64_DIGITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] code;
        logic       valid;
        logic       done;
        logic       status;
        logic [7:0] len;
    } t_text_item;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [7:0]  i_cfg_data    = '0;

    // predictor copy of the registers and the message state
    logic        enc_mode;
    logic [7:0]  enc_capacity;
    logic [6:0]  enc_length;
    logic [15:0] held_pair;
    logic [1:0]  group_count;
    logic [6:0]  bytes_taken;
    logic [7:0]  text_written;

    t_text_item pending_text[$];
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    logic [7:0] rx_cycle = '0;

    digest_hex_base64_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void push_text(input logic [7:0] code, input logic valid,
                                      input logic done, input logic status,
                                      input logic [7:0] len);
        t_text_item it;
        it = '{code, valid, done, status, len};
        pending_text.insert(pending_text.size(), it);
    endfunction

    // base64 characters are dropped once the capacity is used up
    function automatic void push_b64(input logic [7:0] code);
        if (text_written < enc_capacity) begin
            push_text(code, 1'b1, 1'b0, 1'b0, 8'd0);
            text_written = text_written + 8'd1;
        end
    endfunction

    function automatic logic [7:0] b64_digit(input logic [5:0] idx);
        return B64_DIGITS[8 * (63 - int'(idx)) +: 8];
    endfunction

    function automatic void encode_group(input logic [7:0] t0, input logic [7:0] t1,
                                         input logic [7:0] t2, input int count);
        push_b64(b64_digit(t0[7:2]));
        push_b64(b64_digit({t0[1:0], t1[7:4]}));
        push_b64(count >= 2 ? b64_digit({t1[3:0], t2[7:6]}) : PAD_CHAR);
        push_b64(count >= 3 ? b64_digit(t2[5:0]) : PAD_CHAR);
    endfunction

    function automatic int effective_length(input logic [6:0] len);
        if (len < 7'd1) return 1;
        if (len > 7'(MAX_DIGEST_BYTES)) return MAX_DIGEST_BYTES;
        return int'(len);
    endfunction

    function automatic void encode_byte(input logic [7:0] b);
        int   eff;
        logic last;
        logic fits;
        int   fill;
        eff = effective_length(enc_length);
        last = (int'(bytes_taken) + 1 >= eff);
        bytes_taken = bytes_taken + 7'd1;
        if (enc_mode == MODE_HEX) begin
            fits = (2 * eff <= int'(enc_capacity));
            if (fits) begin
                push_text(HEX_DIGITS[8 * (15 - int'(b[7:4])) +: 8], 1'b1, 1'b0, 1'b0, 8'd0);
                push_text(HEX_DIGITS[8 * (15 - int'(b[3:0])) +: 8], 1'b1, 1'b0, 1'b0, 8'd0);
                text_written = text_written + 8'd2;
            end
            if (last) begin
                if (!fits)
                    push_text(TERM_CHAR, 1'b0, 1'b1, 1'b1, 8'd0);
                else if (int'(enc_capacity) > int'(text_written) + 1)
                    push_text(TERM_CHAR, 1'b1, 1'b1, 1'b0, text_written + 8'd1);
                else
                    push_text(TERM_CHAR, 1'b0, 1'b1, 1'b0, text_written);
            end
        end else begin
            fill = int'(group_count) + 1;
            if (fill >= 3) begin
                encode_group(held_pair[15:8], held_pair[7:0], b, 3);
                fill = 0;
            end else if (last) begin
                if (fill == 1)
                    encode_group(b, 8'd0, 8'd0, 1);
                else
                    encode_group(held_pair[7:0], b, 8'd0, 2);
            end
            held_pair = {held_pair[7:0], b};
            group_count = 2'(fill);
            if (last) begin
                if (text_written < enc_capacity)
                    push_text(TERM_CHAR, 1'b1, 1'b1, 1'b0, text_written + 8'd1);
                else
                    push_text(TERM_CHAR, 1'b0, 1'b1, 1'b1, 8'd0);
            end
        end
        if (last) begin
            held_pair = '0;
            group_count = '0;
            bytes_taken = '0;
            text_written = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        bytes_sent++;
        encode_byte(b);
    endtask

    task automatic stop_bytes();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_text_drained();
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_TEXT_MODE:     enc_mode     = value[0];
            CFG_DEST_CAPACITY: enc_capacity = value;
            CFG_DIGEST_LENGTH: enc_length   = value[6:0];
            default: ;
        endcase
    endtask

    // registers change only once the encoder has nothing left to send
    task automatic write_regs(input logic [2:0] en, input logic [7:0] mode_v,
                              input logic [7:0] cap_v, input logic [7:0] len_v);
        stop_bytes();
        wait_text_drained();
        if (en[0]) write_reg(CFG_TEXT_MODE, mode_v);
        if (en[1]) write_reg(CFG_DEST_CAPACITY, cap_v);
        if (en[2]) write_reg(CFG_DIGEST_LENGTH, len_v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic finish_message();
        do send_byte(8'($urandom)); while (bytes_taken != 0);
    endtask

    function automatic logic [7:0] pick_length();
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r == 0) len = 0;
        else if (r == 1) len = $urandom_range(65, 127);
        else if (r == 2) len = $urandom_range(10, 64);
        else len = $urandom_range(1, 9);
        return {1'($urandom), 7'(len)};
    endfunction

    function automatic logic [7:0] pick_capacity(input logic mode, input logic [7:0] len_v);
        int eff;
        int need;
        int r;
        eff = effective_length(len_v[6:0]);
        need = (mode == MODE_HEX) ? 2 * eff : 4 * ((eff + 2) / 3);
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'($urandom);
        need = need + $urandom_range(0, 5) - 2;
        if (need < 0) need = 0;
        if (need > 255) need = 255;
        return 8'(need);
    endfunction

    task automatic test_hex_extremes();
        write_regs(3'b111, {7'd0, MODE_HEX}, 8'd255, 8'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h9A);
    endtask

    task automatic test_hex_room();
        write_regs(3'b111, {7'd0, MODE_HEX}, 8'd3, 8'd2);
        send_byte(8'h12);
        send_byte(8'hEF);
        write_regs(3'b010, 8'd0, 8'd5, 8'd0);
        send_byte(8'h34);
        send_byte(8'hCD);
        write_regs(3'b010, 8'd0, 8'd6, 8'd0);
        send_byte(8'h56);
        send_byte(8'hAB);
    endtask

    task automatic test_b64_padding();
        write_regs(3'b111, {7'd0, MODE_B64}, 8'd255, 8'd1);
        send_byte(8'h00);
        write_regs(3'b100, 8'd0, 8'd0, 8'd2);
        send_byte(8'hFB);
        send_byte(8'hEF);
        write_regs(3'b100, 8'd0, 8'd0, 8'd3);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    task automatic test_b64_overflow();
        write_regs(3'b111, {7'd0, MODE_B64}, 8'd0, 8'd1);
        send_byte(8'h4D);
        write_regs(3'b010, 8'd0, 8'd2, 8'd0);
        send_byte(8'h4D);
        write_regs(3'b010, 8'd0, 8'd4, 8'd0);
        send_byte(8'hC3);
        write_regs(3'b010, 8'd0, 8'd5, 8'd0);
        send_byte(8'hA5);
    endtask

    // length lowered below the bytes already taken closes the message on the next byte
    task automatic test_length_cut();
        write_regs(3'b111, {7'd0, MODE_B64}, 8'd255, 8'd4);
        send_byte(8'h61);
        send_byte(8'h62);
        write_regs(3'b100, 8'd0, 8'd0, 8'd1);
        send_byte(8'h63);
    endtask

    task automatic test_random_messages();
        int         target;
        logic       mode;
        logic [7:0] len_v;
        int         pick;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) < 6) begin
                mode  = 1'($urandom);
                len_v = pick_length();
                write_regs(3'b111, {7'($urandom), mode}, pick_capacity(mode, len_v), len_v);
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                pick = $urandom_range(0, 2);
                mode = 1'($urandom);
                len_v = pick_length();
                write_regs(3'b001 << pick, {7'($urandom), mode},
                           pick_capacity(mode, len_v), len_v);
            end
            finish_message();
        end
    endtask

    initial begin
        enc_mode     = MODE_HEX;
        enc_capacity = 8'd0;
        enc_length   = 7'd32;
        held_pair    = '0;
        group_count  = '0;
        bytes_taken  = '0;
        text_written = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hex_extremes();
        test_hex_room();
        test_b64_padding();
        test_b64_overflow();
        test_length_cut();
        test_random_messages();
        stop_bytes();
        wait_text_drained();
        if (mismatches == 0 && pending_text.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver pattern: free running, random, periodic, long stalls
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        case (rx_cycle[7:6])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= (rx_cycle % 3 == 0);
            default: m_axis_tready <= (rx_cycle[3:0] > 4'd9);
        endcase
    end

    always @(posedge i_clk) begin : text_check
        t_text_item got;
        t_text_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
                    m_axis_tdata[8], m_axis_tdata[16:9]};
            if (pending_text.size() == 0) begin
                report_mismatch("unexpected item", int'(got), 0);
            end else begin
                want = pending_text.pop_front();
                if (got.code != want.code)
                    report_mismatch("char_code", got.code, want.code);
                if (got.valid != want.valid)
                    report_mismatch("char_valid", got.valid, want.valid);
                if (got.done != want.done)
                    report_mismatch("done", got.done, want.done);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.len != want.len)
                    report_mismatch("final_length", got.len, want.len);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
